/* rtl/cia_pkg.sv */
// Package for the checked integer ALU: operation codes, control bundle, defaults.
// No dependencies; used by the interfaces, the divide cell and the top level.
`default_nettype none
package cia_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int PORT_WIDTH     = 32;
    localparam int FUNC_WIDTH     = 2;

    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    // control that travels with each request down the cell chain
    typedef struct packed {
        logic vld;
        logic is_div;
        logic err;
        logic qneg;
    } t_ctl;

endpackage
`default_nettype wire

/* rtl/cia_req_if.sv */
// Request channel interface: valid/ready handshake with opcode and two operands.
// Depends on cia_pkg for field widths.
`default_nettype none
interface cia_req_if;
    logic                              valid;
    logic                              ready;
    logic [cia_pkg::FUNC_WIDTH-1:0]    func;
    logic signed [cia_pkg::PORT_WIDTH-1:0] operand_a;
    logic signed [cia_pkg::PORT_WIDTH-1:0] operand_b;

    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

/* rtl/cia_rsp_if.sv */
// Response channel interface: valid/ready handshake with result value and error flag.
// Depends on cia_pkg for field widths.
`default_nettype none
interface cia_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cia_pkg::PORT_WIDTH-1:0] value;
    logic                                  error;

    modport source (output valid, value, error, input ready);
    modport sink   (input valid, value, error, output ready);
endinterface
`default_nettype wire

/* rtl/checked_integer_alu_core.sv */
// Top level of the checked integer ALU: operand prep, divide cell chain, output register.
// Depends on cia_pkg, cia_req_if, cia_rsp_if and cia_div_cell.
//
//  channel | dir | modport | payload
//  i_req   | in  | sink    | func, operand_a, operand_b
//  o_rsp   | out | source  | value, error
//
// Every request passes through one prep stage, one cell per quotient bit of the divide
// chain, and the output register.
// One request enters per cycle unless the response stalls; all stages advance together.
// Reset clears every stage's valid bit; the pipeline is empty after reset.
// A stalled response freezes the whole chain, and i_req.ready drops with it.
`default_nettype none
module checked_integer_alu_core #(
    parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cia_req_if.sink   i_req,
    cia_rsp_if.source o_rsp
);

    localparam int W = DATA_WIDTH;

    // chain taps: index 0 is the prep register, index W the last cell
    cia_pkg::t_ctl  c_ctl [0:W];
    logic [W-1:0]   c_rem [0:W];
    logic [W-1:0]   c_dq  [0:W];
    logic [W-1:0]   c_dvs [0:W];
    logic [W-1:0]   c_res [0:W];

    logic advance;

    // hold everything while a finished result waits
    assign advance     = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = advance;

    // ---------------- prep stage ----------------
    logic signed [W-1:0]   a_s;
    logic signed [W-1:0]   b_s;
    logic [W:0]            sum_w;
    logic [W:0]            dif_w;
    logic signed [2*W-1:0] prod;
    logic [W-1:0]          mag_a;
    logic [W-1:0]          mag_b;
    cia_pkg::t_ctl         n_ctl;
    logic [W-1:0]          n_res;

    always_comb begin
        a_s   = i_req.operand_a[W-1:0];
        b_s   = i_req.operand_b[W-1:0];
        sum_w = {a_s[W-1], a_s} + {b_s[W-1], b_s};
        dif_w = {a_s[W-1], a_s} - {b_s[W-1], b_s};
        prod  = (2*W)'(a_s) * (2*W)'(b_s);
        mag_a = a_s[W-1] ? (~a_s + 1'b1) : a_s;
        mag_b = b_s[W-1] ? (~b_s + 1'b1) : b_s;

        n_ctl.vld    = i_req.valid;
        n_ctl.is_div = 1'b0;
        n_ctl.err    = 1'b0;
        n_ctl.qneg   = a_s[W-1] ^ b_s[W-1];
        n_res        = '0;

        unique case (cia_pkg::t_func'(i_req.func))
            cia_pkg::FUNC_ADD: begin
                n_ctl.err = sum_w[W] ^ sum_w[W-1];
                n_res     = sum_w[W-1:0];
            end
            cia_pkg::FUNC_SUB: begin
                n_ctl.err = dif_w[W] ^ dif_w[W-1];
                n_res     = dif_w[W-1:0];
            end
            cia_pkg::FUNC_MUL: begin
                // the upper half plus the sign bit must all match
                n_ctl.err = (prod[2*W-1:W-1] != '0) && (prod[2*W-1:W-1] != '1);
                n_res     = prod[W-1:0];
            end
            cia_pkg::FUNC_DIV: begin
                n_ctl.is_div = 1'b1;
                n_ctl.err    = (mag_b == '0);
            end
            default: begin
                n_ctl.err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_ctl[0] <= '0;
        end else if (advance) begin
            c_ctl[0] <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            c_rem[0] <= '0;
            c_dq[0]  <= mag_a;
            c_dvs[0] <= mag_b;
            c_res[0] <= n_res;
        end
    end

    // ---------------- divide cell chain ----------------
    for (genvar g = 0; g < W; g++) begin : g_cell
        cia_div_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_ctl   (c_ctl[g]),
            .i_rem   (c_rem[g]),
            .i_dq    (c_dq[g]),
            .i_dvs   (c_dvs[g]),
            .i_res   (c_res[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_dq    (c_dq[g+1]),
            .o_dvs   (c_dvs[g+1]),
            .o_res   (c_res[g+1])
        );
    end

    // ---------------- finish and output register ----------------
    cia_pkg::t_ctl       ctl_w;
    logic [W-1:0]        quo;
    logic                fin_err;
    logic signed [W-1:0] fin_val;
    logic signed [cia_pkg::PORT_WIDTH-1:0] n_out_val;

    logic                                  r_out_vld;
    logic                                  r_out_err;
    logic signed [cia_pkg::PORT_WIDTH-1:0] r_out_val;

    always_comb begin
        ctl_w = c_ctl[W];
        quo   = ctl_w.qneg ? (~c_dq[W] + 1'b1) : c_dq[W];
        if (ctl_w.is_div) begin
            // a positive quotient of magnitude 2^(W-1) only comes from min / -1
            fin_err = ctl_w.err || (!ctl_w.qneg && c_dq[W][W-1]);
            fin_val = quo;
        end else begin
            fin_err = ctl_w.err;
            fin_val = c_res[W];
        end
        if (fin_err) begin
            fin_val = '0;
        end
        // sign-extend to the port width
        n_out_val = cia_pkg::PORT_WIDTH'(fin_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= ctl_w.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_err <= fin_err;
            r_out_val <= n_out_val;
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.error = r_out_err;
    assign o_rsp.value = r_out_val;

    // ---------------- assertions ----------------
    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.error) |-> (o_rsp.value == '0))
        else $error("flagged result carries a nonzero value");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("response valid right after reset");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (o_rsp.valid && !o_rsp.ready))
        else $error("request stalled without output back-pressure");

endmodule
`default_nettype wire

/* rtl/cia_div_cell.sv */
// One cell of the divide chain: a restoring division step, registered.
// Control and result of non-divide requests pass through unchanged. Depends on cia_pkg.
`default_nettype none
module cia_div_cell #(
    parameter int W = cia_pkg::DATA_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire cia_pkg::t_ctl i_ctl,
    input  wire logic [W-1:0]  i_rem,
    input  wire logic [W-1:0]  i_dq,
    input  wire logic [W-1:0]  i_dvs,
    input  wire logic [W-1:0]  i_res,
    output cia_pkg::t_ctl      o_ctl,
    output logic [W-1:0]       o_rem,
    output logic [W-1:0]       o_dq,
    output logic [W-1:0]       o_dvs,
    output logic [W-1:0]       o_res
);

    logic [W:0]   rem2;
    logic [W:0]   diff;
    logic         take;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_dq;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        rem2  = {i_rem, i_dq[W-1]};
        diff  = rem2 - {1'b0, i_dvs};
        take  = (rem2 >= {1'b0, i_dvs});
        n_rem = take ? diff[W-1:0] : rem2[W-1:0];
        n_dq  = {i_dq[W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_dq  <= n_dq;
            o_dvs <= i_dvs;
            o_res <= i_res;
        end
    end

endmodule
`default_nettype wire
